/* hdl/jmvc_pkg.sv */
// Package for the Jones matrix visibility correction unit.
// Holds the field widths, the command codes and the structs shared by the lanes,
// the station table, the output queue and the top level. It depends on nothing.
package jmvc_pkg;

  localparam int JONES_W    = 18;
  localparam int VIS_W      = 32;
  localparam int ST_W       = 6;
  localparam int N_CPLX     = 4;
  localparam int ROW_W      = 2 * N_CPLX * JONES_W;
  localparam int VIS_ROW_W  = 2 * N_CPLX * VIS_W;
  localparam int IN_DATA_W  = 272;
  localparam int OUT_DATA_W = VIS_ROW_W;
  localparam int OUT_DEPTH  = 8;
  localparam int CNT_W      = $clog2(OUT_DEPTH + 1);

  typedef enum logic {
    CMD_APPLY = 1'b0,
    CMD_LOAD  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                  push;
    logic [OUT_DATA_W-1:0] data;
  } out_push_t;

endpackage

/* hdl/jmvc_lane.sv */
// One complex multiply-accumulate lane: (a*b + c*d), or with a and c conjugated.
// Two register stages: products, then sum with round half up by FRAC_W bits.
// Depends on jmvc_pkg.
module jmvc_lane import jmvc_pkg::*; #(
  parameter int DATA_W = 32,
  parameter int FRAC_W = 16,
  parameter bit CONJ   = 1'b0,
  localparam int PROD_W = JONES_W + DATA_W,
  localparam int SUM_W  = PROD_W + 3,
  localparam int OUT_W  = SUM_W - FRAC_W
) (
  input  logic                     clk_i,
  input  logic signed [JONES_W-1:0] a_re_i,
  input  logic signed [JONES_W-1:0] a_im_i,
  input  logic signed [DATA_W-1:0]  b_re_i,
  input  logic signed [DATA_W-1:0]  b_im_i,
  input  logic signed [JONES_W-1:0] c_re_i,
  input  logic signed [JONES_W-1:0] c_im_i,
  input  logic signed [DATA_W-1:0]  d_re_i,
  input  logic signed [DATA_W-1:0]  d_im_i,
  output logic signed [OUT_W-1:0]   re_o,
  output logic signed [OUT_W-1:0]   im_o
);

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_W - 1);

  logic signed [PROD_W-1:0] prod_q [8];
  logic signed [SUM_W-1:0]  re_sum, im_sum, re_rnd, im_rnd;
  logic signed [OUT_W-1:0]  re_q, im_q;

  always_ff @(posedge clk_i) begin
    prod_q[0] <= a_re_i * b_re_i;
    prod_q[1] <= a_im_i * b_im_i;
    prod_q[2] <= a_re_i * b_im_i;
    prod_q[3] <= a_im_i * b_re_i;
    prod_q[4] <= c_re_i * d_re_i;
    prod_q[5] <= c_im_i * d_im_i;
    prod_q[6] <= c_re_i * d_im_i;
    prod_q[7] <= c_im_i * d_re_i;
  end

  always_comb begin
    if (CONJ) begin
      re_sum = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[4]) + SUM_W'(prod_q[5]);
      im_sum = SUM_W'(prod_q[2]) - SUM_W'(prod_q[3]) + SUM_W'(prod_q[6]) - SUM_W'(prod_q[7]);
    end else begin
      re_sum = SUM_W'(prod_q[0]) - SUM_W'(prod_q[1]) + SUM_W'(prod_q[4]) - SUM_W'(prod_q[5]);
      im_sum = SUM_W'(prod_q[2]) + SUM_W'(prod_q[3]) + SUM_W'(prod_q[6]) + SUM_W'(prod_q[7]);
    end
    re_rnd = re_sum + HALF;
    im_rnd = im_sum + HALF;
  end

  // drop the fraction bits: floor after adding half
  always_ff @(posedge clk_i) begin
    re_q <= re_rnd[SUM_W-1:FRAC_W];
    im_q <= im_rnd[SUM_W-1:FRAC_W];
  end

  assign re_o = re_q;
  assign im_o = im_q;

endmodule

/* hdl/jmvc_table.sv */
// Station table: one Jones matrix row of eight 18-bit values per station.
// One write port, two registered read ports. Depends on jmvc_pkg.
module jmvc_table import jmvc_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [ROW_W-1:0] wr_row_i,
  input  logic [AW-1:0]    rd_p_addr_i,
  input  logic [AW-1:0]    rd_q_addr_i,
  output logic [ROW_W-1:0] rd_p_row_o,
  output logic [ROW_W-1:0] rd_q_row_o
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] p_row_q, q_row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
    p_row_q <= mem[rd_p_addr_i];
    q_row_q <= mem[rd_q_addr_i];
  end

  assign rd_p_row_o = p_row_q;
  assign rd_q_row_o = q_row_q;

endmodule

/* hdl/jmvc_out_fifo.sv */
// Output queue of corrected visibilities, OUT_DEPTH items deep.
// Absorbs what the pipeline has in flight when the sink stalls. Depends on jmvc_pkg.
module jmvc_out_fifo import jmvc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  out_push_t             push_i,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [CNT_W-1:0]      count_o
);

  localparam int PW = $clog2(OUT_DEPTH);

  logic [OUT_DATA_W-1:0] mem [OUT_DEPTH];
  logic [PW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  pop;

  assign pop = m_tvalid && m_tready;

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem[wr_ptr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.push) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop)         rd_ptr_q <= rd_ptr_q + PW'(1);
      case ({push_i.push, pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign m_tvalid = (cnt_q != '0);
  assign m_tdata  = mem[rd_ptr_q];
  assign count_o  = cnt_q;

endmodule

/* hdl/jones_matrix_visibility_correct_unit.sv */
// Jones matrix visibility correction: top level with table, two lane rows and output queue.
// Depends on jmvc_pkg, jmvc_table, jmvc_lane and jmvc_out_fifo.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+--------------------------------------
//   s_       | in  | s_tvalid / s_tready | s_tuser command, s_tdata station+vis
//   m_       | out | m_tvalid / m_tready | m_tdata corrected visibility
//
// One item per cycle while s_tready is high. An apply item passes the table read, the conjugated
// Jq lanes, the Jp lanes and a queue write before it shows at m_.
// Load items write the table at acceptance and give no result; an apply in the next
// cycle already sees the new row. No clearing pass: unwritten stations read garbage.
// On a sink stall the 8-item output queue fills; s_tready drops when queue plus in-flight
// items reach 8.
module jones_matrix_visibility_correct_unit import jmvc_pkg::*; #(
  parameter int MAX_STATIONS    = 64,
  parameter int COEFF_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [0] command
  input  logic                  s_tuser,
  // station_p, station_q, e0_re, e0_im, e1_re, e1_im, e2_re, e2_im, e3_re, e3_im, pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_xx_re, out_xx_im, out_xy_re, out_xy_im, out_yx_re, out_yx_im, out_yy_re, out_yy_im
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int AW    = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam int A_W   = JONES_W + VIS_W + 3 - COEFF_FRAC_BITS;
  localparam int R_W   = JONES_W + A_W + 3 - COEFF_FRAC_BITS;
  localparam int X_W   = (R_W > VIS_W) ? R_W : VIS_W + 1;
  localparam int NST   = 5;
  localparam int FL_W  = $clog2(NST + 1);
  localparam logic signed [X_W-1:0] SMAX = X_W'(64'sd2147483647);
  localparam logic signed [X_W-1:0] SMIN = -X_W'(64'sd2147483648);

  logic                 acc;
  cmd_e                 cmd;
  logic [ST_W-1:0]      st_p, st_q;
  logic                 p_ok, q_ok;
  logic [ST_W+AW-1:0]   p_ext, q_ext;
  logic [AW-1:0]        p_addr, q_addr;
  logic [ROW_W-1:0]     wr_row, jp_row, jq_row;
  logic [VIS_ROW_W-1:0] vis_in;

  logic [NST-1:0]       vld_q, pass_q;
  logic [VIS_ROW_W-1:0] vis_q [NST];
  logic [ROW_W-1:0]     jp_s1_q, jp_s2_q;
  logic [FL_W-1:0]      inflight;
  logic [CNT_W-1:0]     fifo_cnt;
  out_push_t            push;

  assign acc   = s_tvalid && s_tready;
  assign cmd   = cmd_e'(s_tuser);
  assign st_p  = s_tdata[ST_W-1:0];
  assign st_q  = s_tdata[2*ST_W-1:ST_W];
  assign p_ok  = (32'(st_p) < 32'(MAX_STATIONS));
  assign q_ok  = (32'(st_q) < 32'(MAX_STATIONS));
  assign p_ext = (ST_W+AW)'(st_p);
  assign q_ext = (ST_W+AW)'(st_q);
  assign p_addr = p_ok ? p_ext[AW-1:0] : '0;
  assign q_addr = q_ok ? q_ext[AW-1:0] : '0;
  assign vis_in = s_tdata[2*ST_W +: VIS_ROW_W];

  // keep the low 18 bits of each load field
  always_comb begin
    for (int i = 0; i < 2 * N_CPLX; i++) begin
      wr_row[i*JONES_W +: JONES_W] = vis_in[i*VIS_W +: JONES_W];
    end
  end

  jmvc_table #(.DEPTH(MAX_STATIONS), .AW(AW)) u_table (
    .clk_i      (clk_i),
    .wr_en_i    (acc && (cmd == CMD_LOAD) && p_ok),
    .wr_addr_i  (p_addr),
    .wr_row_i   (wr_row),
    .rd_p_addr_i(p_addr),
    .rd_q_addr_i(q_addr),
    .rd_p_row_o (jp_row),
    .rd_q_row_o (jq_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NST-2:0], acc && (cmd == CMD_APPLY)};
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q   <= {pass_q[NST-2:0], (st_p == st_q) || !p_ok || !q_ok};
    vis_q[0] <= vis_in;
    for (int s = 1; s < NST; s++) begin
      vis_q[s] <= vis_q[s-1];
    end
    jp_s1_q <= jp_row;
    jp_s2_q <= jp_s1_q;
  end

  // first lane row: conj(Jq) against the visibility pairs
  logic signed [A_W-1:0] mid_re [N_CPLX];
  logic signed [A_W-1:0] mid_im [N_CPLX];
  logic signed [R_W-1:0] res_re [N_CPLX];
  logic signed [R_W-1:0] res_im [N_CPLX];

  for (genvar k = 0; k < N_CPLX; k++) begin : g_lanes
    localparam int C0 = (k / 2) * 2;
    localparam int C1 = C0 + 1;
    localparam int D0 = (k % 2) * 2;
    localparam int D1 = D0 + 1;

    jmvc_lane #(.DATA_W(VIS_W), .FRAC_W(COEFF_FRAC_BITS), .CONJ(1'b1)) u_lane_q (
      .clk_i (clk_i),
      .a_re_i(jq_row[(2*C0)*JONES_W +: JONES_W]),
      .a_im_i(jq_row[(2*C0+1)*JONES_W +: JONES_W]),
      .b_re_i(vis_q[0][(2*D0)*VIS_W +: VIS_W]),
      .b_im_i(vis_q[0][(2*D0+1)*VIS_W +: VIS_W]),
      .c_re_i(jq_row[(2*C1)*JONES_W +: JONES_W]),
      .c_im_i(jq_row[(2*C1+1)*JONES_W +: JONES_W]),
      .d_re_i(vis_q[0][(2*D1)*VIS_W +: VIS_W]),
      .d_im_i(vis_q[0][(2*D1+1)*VIS_W +: VIS_W]),
      .re_o  (mid_re[k]),
      .im_o  (mid_im[k])
    );

    jmvc_lane #(.DATA_W(A_W), .FRAC_W(COEFF_FRAC_BITS), .CONJ(1'b0)) u_lane_p (
      .clk_i (clk_i),
      .a_re_i(jp_s2_q[(2*C0)*JONES_W +: JONES_W]),
      .a_im_i(jp_s2_q[(2*C0+1)*JONES_W +: JONES_W]),
      .b_re_i(mid_re[D0]),
      .b_im_i(mid_im[D0]),
      .c_re_i(jp_s2_q[(2*C1)*JONES_W +: JONES_W]),
      .c_im_i(jp_s2_q[(2*C1+1)*JONES_W +: JONES_W]),
      .d_re_i(mid_re[D1]),
      .d_im_i(mid_im[D1]),
      .re_o  (res_re[k]),
      .im_o  (res_im[k])
    );
  end

  // merge: saturate lane results or pass the visibility through
  function automatic logic [VIS_W-1:0] sat(input logic signed [X_W-1:0] x);
    logic signed [X_W-1:0] y;
    if (x > SMAX)      y = SMAX;
    else if (x < SMIN) y = SMIN;
    else               y = x;
    return y[VIS_W-1:0];
  endfunction

  always_comb begin
    push.push = vld_q[NST-1];
    for (int k = 0; k < N_CPLX; k++) begin
      if (pass_q[NST-1]) begin
        push.data[2*k*VIS_W +: 2*VIS_W] = vis_q[NST-1][2*k*VIS_W +: 2*VIS_W];
      end else begin
        push.data[2*k*VIS_W +: VIS_W]     = sat(X_W'(res_re[k]));
        push.data[(2*k+1)*VIS_W +: VIS_W] = sat(X_W'(res_im[k]));
      end
    end
  end

  jmvc_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .count_o (fifo_cnt)
  );

  assign inflight = FL_W'($countones(vld_q));
  assign s_tready = ((CNT_W + FL_W)'(fifo_cnt) + (CNT_W + FL_W)'(inflight))
                    < (CNT_W + FL_W)'(OUT_DEPTH);

`ifndef ASSERT_OFF
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(fifo_cnt) + 32'(inflight)) <= OUT_DEPTH)
    else $error("output queue credit exceeded");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push |-> (fifo_cnt < CNT_W'(OUT_DEPTH)) || (m_tvalid && m_tready))
    else $error("push into full output queue");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (cmd == CMD_LOAD)) |=> !vld_q[0])
    else $error("load item entered result pipeline");

  a_apply_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (cmd == CMD_APPLY)) |=> vld_q[0])
    else $error("apply item lost");
`endif

endmodule
